/* hw/rtl/irq_line_allocator_defines.svh */
// ----------------------------------------------------------------------------
// irq_line_allocator_defines.svh - assertion macros
// Assertion wrappers for the interrupt line allocator. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef IRQ_LINE_ALLOCATOR_DEFINES_SVH
`define IRQ_LINE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Checks that an expression holds at every clock edge outside reset.
`define ILA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define ILA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ILA_ASSERT(lbl, clk, rst_n, prop, msg)
`define ILA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hw/rtl/ila_pkg.sv */
// ----------------------------------------------------------------------------
// ila_pkg - shared definitions of the interrupt line allocator
// Sizes, command and status codes, and the free-line search result type.
// ----------------------------------------------------------------------------
package ila_pkg;

	localparam int NUM_SOURCES = 64;
	localparam int NUM_LINES   = 31;

	localparam int SRC_W   = 6;
	localparam int LINE_W  = 5;
	localparam int CAUSE_W = 10;
	localparam int LEVEL_W = 4;
	localparam int MASK_W  = 32;

	localparam int SADDR_W = $clog2(NUM_SOURCES);
	localparam int LIDX_W  = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

	localparam logic [LINE_W-1:0]  MUX_DISABLED_CODE = LINE_W'(6);
	localparam logic [LEVEL_W-1:0] THRESHOLD_RESET   = LEVEL_W'(1);

	typedef enum logic [1:0] {
		CMD_ENABLE    = 2'd0,
		CMD_DISABLE   = 2'd1,
		CMD_GET_INTID = 2'd2,
		CMD_SET_LEVEL = 2'd3
	} ila_cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FREE  = 2'd1,
		ST_UNMAPPED = 2'd2
	} ila_status_t;

	typedef struct packed {
		logic              done;
		logic              found;
		logic [LINE_W-1:0] line;
	} ila_scan_res_t;

endpackage

/* hw/rtl/ila_ram.sv */
// ----------------------------------------------------------------------------
// ila_ram - generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ila_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/ila_free_scan.sv */
// ----------------------------------------------------------------------------
// ila_free_scan - first-fit free line search
// Tests one line valid bit per cycle from line 1 upward and reports the first
// free line, or that none is free.
// ----------------------------------------------------------------------------
module ila_free_scan (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ila_pkg::NUM_LINES-1:0]  line_valid,
	output ila_pkg::ila_scan_res_t         res
);

	localparam logic [ila_pkg::LIDX_W-1:0] LAST_IDX = ila_pkg::LIDX_W'(ila_pkg::NUM_LINES - 1);

	logic                        busy_q;
	logic [ila_pkg::LIDX_W-1:0]  idx_q;
	ila_pkg::ila_scan_res_t      res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			res_q  <= '0;
		end else begin
			if (start) begin
				busy_q     <= 1'b1;
				idx_q      <= '0;
				res_q.done <= 1'b0;
			end else if (busy_q) begin
				if (!line_valid[idx_q]) begin
					busy_q      <= 1'b0;
					res_q.done  <= 1'b1;
					res_q.found <= 1'b1;
					res_q.line  <= ila_pkg::LINE_W'(idx_q) + ila_pkg::LINE_W'(1);
				end else if (idx_q == LAST_IDX) begin
					busy_q      <= 1'b0;
					res_q.done  <= 1'b1;
					res_q.found <= 1'b0;
					res_q.line  <= '0;
				end else begin
					idx_q      <= idx_q + ila_pkg::LIDX_W'(1);
					res_q.done <= 1'b0;
				end
			end else begin
				res_q.done <= 1'b0;
			end
		end
	end

	assign res = res_q;

endmodule

/* hw/rtl/irq_line_allocator.sv */
// Path of a transaction: get intid and set level go straight from IDLE to RESP, as does
// a refused source; disable, and enable of a mapped source, pass through READ to RESP; a
// new mapping passes through READ and SCAN, where the free line search runs, to RESP.
// One transaction at a time; the next is taken the cycle after the result leaves, and
// the one-line-per-cycle free search sets the longest interval.
// Reset: asynchronous, active low; all mappings invalid, mask 0, threshold 1.
// ----------------------------------------------------------------------------
// irq_line_allocator - interrupt source to CPU line allocator
// Maps peripheral interrupt sources onto CPU lines 1..NUM_LINES and answers
// enable, disable, cause lookup and threshold commands, one result each.
// ----------------------------------------------------------------------------
`include "irq_line_allocator_defines.svh"

module irq_line_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	// Command channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    command,
	input  logic [ila_pkg::SRC_W-1:0]     source,
	input  logic [ila_pkg::CAUSE_W-1:0]   cause_line,
	input  logic [ila_pkg::LEVEL_W-1:0]   new_level,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [ila_pkg::LINE_W-1:0]    line,
	output logic [ila_pkg::LINE_W-1:0]    map_value,
	output logic [ila_pkg::SRC_W-1:0]     found_source,
	output logic [ila_pkg::LEVEL_W-1:0]   old_level,
	output logic [ila_pkg::MASK_W-1:0]    enable_mask
);

	// The sequencer: IDLE takes a transaction, READ waits for the forward
	// table, SCAN runs the free line search, RESP holds the result.
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_RESP
	} state_t;

	state_t                          state_q;
	ila_pkg::ila_cmd_t               cmd_q;
	logic [ila_pkg::SADDR_W-1:0]     saddr_q;

	// Mapping state. The forward table lives in RAM behind per-source valid
	// bits; the reverse table is a small register file with per-line valid bits.
	logic [ila_pkg::NUM_SOURCES-1:0] src_valid_q;
	logic [ila_pkg::NUM_LINES-1:0]   line_valid_q;
	logic [ila_pkg::SRC_W-1:0]       l2s_q [ila_pkg::NUM_LINES];
	logic [ila_pkg::MASK_W-1:0]      line_en_q;
	logic [ila_pkg::LEVEL_W-1:0]     threshold_q;

	// Result registers.
	ila_pkg::ila_status_t            status_q;
	logic [ila_pkg::LINE_W-1:0]      line_q;
	logic [ila_pkg::LINE_W-1:0]      mapv_q;
	logic [ila_pkg::SRC_W-1:0]       found_q;
	logic [ila_pkg::LEVEL_W-1:0]     oldl_q;

	logic                            in_xact;
	logic                            src_in_range;
	logic                            cause_bad;
	logic [ila_pkg::LIDX_W-1:0]      cause_idx;
	logic [ila_pkg::SADDR_W-1:0]     in_saddr;
	logic [ila_pkg::LINE_W-1:0]      ram_rdata;
	logic [ila_pkg::LIDX_W-1:0]      rd_idx;
	logic                            ram_we;
	logic                            scan_start;
	ila_pkg::ila_scan_res_t          scan_res;
	logic [ila_pkg::LIDX_W-1:0]      scan_idx;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_RESP);
	assign in_xact   = in_valid && !in_stall;

	assign in_saddr     = ila_pkg::SADDR_W'(source);
	assign src_in_range = (32'(source) < ila_pkg::NUM_SOURCES);
	assign cause_bad    = (cause_line == '0) ||
	                      (cause_line > ila_pkg::CAUSE_W'(ila_pkg::NUM_LINES));
	assign cause_idx    = ila_pkg::LIDX_W'(cause_line - ila_pkg::CAUSE_W'(1));
	assign rd_idx       = ila_pkg::LIDX_W'(ram_rdata - ila_pkg::LINE_W'(1));
	assign scan_idx     = ila_pkg::LIDX_W'(scan_res.line - ila_pkg::LINE_W'(1));

	// A new mapping is recorded when the search comes back with a free line.
	assign ram_we     = (state_q == S_SCAN) && scan_res.done && scan_res.found;
	assign scan_start = (state_q == S_READ) && (cmd_q == ila_pkg::CMD_ENABLE) &&
	                    !src_valid_q[saddr_q];

	ila_ram #(
		.WIDTH (ila_pkg::LINE_W),
		.DEPTH (ila_pkg::NUM_SOURCES)
	) u_fwd_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (saddr_q),
		.wdata (scan_res.line),
		.re    (in_xact),
		.raddr (in_saddr),
		.rdata (ram_rdata)
	);

	ila_free_scan u_free_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (scan_start),
		.line_valid (line_valid_q),
		.res        (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= ila_pkg::CMD_ENABLE;
			saddr_q      <= '0;
			src_valid_q  <= '0;
			line_valid_q <= '0;
			line_en_q    <= '0;
			threshold_q  <= ila_pkg::THRESHOLD_RESET;
			status_q     <= ila_pkg::ST_OK;
			line_q       <= '0;
			mapv_q       <= '0;
			found_q      <= '0;
			oldl_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= ila_pkg::ila_cmd_t'(command);
						saddr_q <= in_saddr;
						mapv_q  <= '0;
						unique case (ila_pkg::ila_cmd_t'(command))
							ila_pkg::CMD_ENABLE, ila_pkg::CMD_DISABLE: begin
								line_q  <= '0;
								found_q <= '0;
								oldl_q  <= '0;
								// A source beyond the table is refused before any lookup.
								if (src_in_range) begin
									status_q <= ila_pkg::ST_OK;
									state_q  <= S_READ;
								end else begin
									status_q <= ila_pkg::ST_UNMAPPED;
									state_q  <= S_RESP;
								end
							end
							ila_pkg::CMD_GET_INTID: begin
								oldl_q <= '0;
								// Line zero and lines past the last one never index the table.
								if (cause_bad) begin
									status_q <= ila_pkg::ST_UNMAPPED;
									line_q   <= '0;
									found_q  <= '0;
								end else begin
									line_q <= ila_pkg::LINE_W'(cause_line);
									if (line_valid_q[cause_idx]) begin
										status_q <= ila_pkg::ST_OK;
										found_q  <= l2s_q[cause_idx];
									end else begin
										status_q <= ila_pkg::ST_UNMAPPED;
										found_q  <= '0;
									end
								end
								state_q <= S_RESP;
							end
							ila_pkg::CMD_SET_LEVEL: begin
								status_q    <= ila_pkg::ST_OK;
								line_q      <= '0;
								found_q     <= '0;
								oldl_q      <= threshold_q;
								threshold_q <= new_level;
								state_q     <= S_RESP;
							end
							default: begin
								status_q <= ila_pkg::ST_OK;
								line_q   <= '0;
								found_q  <= '0;
								oldl_q   <= '0;
								state_q  <= S_RESP;
							end
						endcase
					end
				end
				S_READ: begin
					if (cmd_q == ila_pkg::CMD_ENABLE) begin
						if (src_valid_q[saddr_q]) begin
							// Already mapped: keep the line and enable it again.
							line_q               <= ram_rdata;
							mapv_q               <= ram_rdata;
							line_en_q[ram_rdata] <= 1'b1;
							state_q              <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end else begin
						mapv_q <= ila_pkg::MUX_DISABLED_CODE;
						if (src_valid_q[saddr_q]) begin
							line_q               <= ram_rdata;
							line_en_q[ram_rdata] <= 1'b0;
							line_valid_q[rd_idx] <= 1'b0;
							src_valid_q[saddr_q] <= 1'b0;
						end else begin
							status_q <= ila_pkg::ST_UNMAPPED;
						end
						state_q <= S_RESP;
					end
				end
				S_SCAN: begin
					if (scan_res.done) begin
						if (scan_res.found) begin
							line_q                   <= scan_res.line;
							mapv_q                   <= scan_res.line;
							line_en_q[scan_res.line] <= 1'b1;
							line_valid_q[scan_idx]   <= 1'b1;
							l2s_q[scan_idx]          <= ila_pkg::SRC_W'(saddr_q);
							src_valid_q[saddr_q]     <= 1'b1;
						end else begin
							status_q <= ila_pkg::ST_NO_FREE;
						end
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign status       = status_q;
	assign line         = line_q;
	assign map_value    = mapv_q;
	assign found_source = found_q;
	assign old_level    = oldl_q;
	assign enable_mask  = line_en_q;

	// The number of mapped sources equals the number of mapped lines.
	`ILA_ASSERT(a_map_count, clk, arst_n, $countones(src_valid_q) == $countones(line_valid_q), "forward and reverse tables disagree")
	// Only mapped lines can be enabled, and line zero never is.
	`ILA_ASSERT(a_en_mapped, clk, arst_n, ((line_en_q[ila_pkg::NUM_LINES:1] & ~line_valid_q) == '0) && !line_en_q[0], "enable bit set on an unmapped line")
	// A taken transaction closes the command channel until its result leaves.
	`ILA_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_xact, in_stall && !out_valid || out_valid, "command channel open while busy")
	// The table is written only with a line the search actually found.
	`ILA_ASSERT(a_write_line, clk, arst_n, !ram_we || (scan_res.line != '0), "forward table written with line zero")

endmodule
